// ----- rtl/fee_pkg.sv -----
package fee_pkg;

   localparam int SAMPLE_W = 16;
   localparam int DELAY_W  = 13;
   localparam int GAIN_W   = 16;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd16384;
   localparam logic [DELAY_W-1:0] DELAY_RESET = '0;

   // Command codes of the request channel
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_DRAIN  = 1'b1;

   // Register select, taken from paddr bit 2
   localparam logic REG_DELAY = 1'b0;
   localparam logic REG_GAIN  = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

// ----- rtl/fee_req_if.sv -----
interface fee_req_if;
   logic                valid;
   logic                ready;
   logic                command;
   fee_pkg::sample_type in_sample;

   modport source (output valid, output command, output in_sample, input ready);
   modport sink   (input valid, input command, input in_sample, output ready);
endinterface

// ----- rtl/fee_rsp_if.sv -----
interface fee_rsp_if;
   logic                valid;
   logic                ready;
   fee_pkg::sample_type out_sample;
   logic                tail_done;

   modport source (output valid, output out_sample, output tail_done, input ready);
   modport sink   (input valid, input out_sample, input tail_done, output ready);
endinterface

// ----- rtl/feedforward_echo_unit.sv -----
// Feedforward echo unit: mixes each audio sample with a gained copy of the
// sample D positions earlier in the same clip.
// Channels: req_chan carries command and in_sample (command 0 = clip sample,
// 1 = drain one tail sample); rsp_chan returns out_sample and tail_done, one
// transfer per request. Both use valid/ready; a transfer happens when both
// are high at a rising clock edge. The csr_ port is APB-style: delay_samples
// at byte address 0, decay_gain at byte address 4; pready is tied high.
// Path: a request transfer loads the history RAM read register and stage 1;
// the multiply then feeds the result register. Throughput: one request per
// cycle while no receiver stall or remainder rebuild holds ready low, set by
// the single read/write port pair of the history RAM and the one multiplier.
// After a write to delay_samples the request channel holds ready low while a
// serial remainder unit re-aligns the tail position.
// When the receiver stalls, the result register and the RAM stage hold;
// ready drops only once both are full, so no transfer is lost.
// Reset (synchronous, active high) clears the clip state, the pointers and
// the valid flags, sets delay 0 and gain 16384 (0.5). The history RAM is not
// cleared; only entries written in the current clip are ever used.
module feedforward_echo_unit #(
   parameter int MAX_DELAY_DEPTH = 8192
) (
   input  logic                            clock,
   input  logic                            reset,
   fee_req_if.sink                         req_chan,
   fee_rsp_if.source                       rsp_chan,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [fee_pkg::CSR_AW-1:0]      csr_paddr,
   input  logic [fee_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [fee_pkg::CSR_DW-1:0]      csr_prdata,
   output logic                            csr_pready
);

   localparam int PTR_W   = (MAX_DELAY_DEPTH > 1) ? $clog2(MAX_DELAY_DEPTH) : 1;
   localparam int DW      = fee_pkg::DELAY_W;
   localparam int EXT_W   = ((PTR_W > DW) ? PTR_W : DW) + 1;
   localparam int DLIM    = (MAX_DELAY_DEPTH - 1 < 8191) ? MAX_DELAY_DEPTH - 1 : 8191;
   localparam logic [DW-1:0]    D_CAP     = DW'(DLIM);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(MAX_DELAY_DEPTH - 1);
   localparam logic [EXT_W-1:0] DEPTH_EXT = EXT_W'(MAX_DELAY_DEPTH);
   localparam int STEP_W  = 4;
   localparam logic [STEP_W-1:0] STEP_TOP = STEP_W'(DW - 1);

   typedef enum logic [2:0] {
      MODE_PASS,
      MODE_MIX_SELF,
      MODE_MIX_RAM,
      MODE_ZERO,
      MODE_TAIL
   } mode_type;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [DW-1:0]                 delay_ff;
   logic [fee_pkg::GAIN_W-1:0]    gain_ff;
   logic                          csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= fee_pkg::DELAY_RESET;
         gain_ff  <= fee_pkg::GAIN_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            fee_pkg::REG_DELAY: delay_ff <= csr_pwdata[DW-1:0];
            fee_pkg::REG_GAIN:  gain_ff  <= csr_pwdata[fee_pkg::GAIN_W-1:0];
            default:            delay_ff <= delay_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         fee_pkg::REG_DELAY: csr_prdata = {{(fee_pkg::CSR_DW-DW){1'b0}}, delay_ff};
         fee_pkg::REG_GAIN:
            csr_prdata = {{(fee_pkg::CSR_DW-fee_pkg::GAIN_W){1'b0}}, gain_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // Effective delay: saturate at the ring depth minus one, and at 8191
   logic [DW-1:0] eff_d;
   assign eff_d = (delay_ff > D_CAP) ? D_CAP : delay_ff;

   // ---------------------------------------------------------------------
   // Clip state and handshake control
   // ---------------------------------------------------------------------
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [DW-1:0]    clip_count_ff, clip_count_in;
   logic [DW-1:0]    drain_index_ff, drain_index_in;
   logic [DW-1:0]    drain_rem_ff;        // drain_index mod D
   logic             rem_busy_ff;
   logic [STEP_W-1:0] rem_step_ff;

   logic             s1_valid_ff, s1_valid_in;
   mode_type         s1_mode_ff, s1_mode_in;
   logic             s1_done_ff, s1_done_in;
   fee_pkg::sample_type s1_x_ff;
   fee_pkg::sample_type ram_q_ff;

   logic             out_valid_ff, out_valid_in;
   fee_pkg::sample_type out_sample_ff, out_sample_in;
   logic             tail_done_ff;

   logic             out_free, s1_adv, accept, is_sample;
   logic [DW-1:0]    back;
   logic [DW:0]      drain_sum, drain_next;
   logic [EXT_W-1:0] addr_diff, addr_fix;
   logic [PTR_W-1:0] rd_addr;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !rem_busy_ff && (!s1_valid_ff || out_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_sample      = (req_chan.command == fee_pkg::CMD_SAMPLE);

   assign drain_sum  = {1'b0, drain_index_ff} + {1'b0, clip_count_ff};
   assign drain_next = {1'b0, drain_index_ff} + {{DW{1'b0}}, 1'b1};

   // Ring slot that lies 'back' positions behind the write pointer
   assign back      = is_sample ? eff_d : (eff_d - drain_rem_ff);
   assign addr_diff = EXT_W'(wp_ff) - EXT_W'(back);
   assign addr_fix  = addr_diff[EXT_W-1] ? (addr_diff + DEPTH_EXT) : addr_diff;
   assign rd_addr   = addr_fix[PTR_W-1:0];

   always_comb begin
      wp_in          = wp_ff;
      clip_count_in  = clip_count_ff;
      drain_index_in = drain_index_ff;
      s1_mode_in     = MODE_ZERO;
      s1_done_in     = 1'b0;
      if (is_sample) begin
         // Clip sample: advance the ring and restart any pending tail
         drain_index_in = '0;
         wp_in          = (wp_ff == PTR_LAST) ? '0 : wp_ff + PTR_W'(1);
         if (clip_count_ff < eff_d) begin
            s1_mode_in    = MODE_PASS;
            clip_count_in = clip_count_ff + DW'(1);
         end else begin
            s1_mode_in    = (eff_d == '0) ? MODE_MIX_SELF : MODE_MIX_RAM;
            clip_count_in = eff_d;
         end
      end else begin
         // Drain: positions before the clip start give zero
         if (eff_d == '0 || drain_sum < {1'b0, eff_d}) begin
            s1_mode_in = MODE_ZERO;
         end else begin
            s1_mode_in = MODE_TAIL;
         end
         if (eff_d == '0 || drain_next >= {1'b0, eff_d}) begin
            s1_done_in     = 1'b1;
            clip_count_in  = '0;
            drain_index_in = '0;
         end else begin
            drain_index_in = drain_next[DW-1:0];
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Remainder unit: after a delay write, rebuild drain_index mod D with a
   // restoring subtract, one quotient bit per cycle.
   // ---------------------------------------------------------------------
   logic [2*DW-1:0] rem_trial;
   assign rem_trial = {{DW{1'b0}}, eff_d} << rem_step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff          <= '0;
         clip_count_ff  <= '0;
         drain_index_ff <= '0;
         drain_rem_ff   <= '0;
         rem_busy_ff    <= 1'b0;
         rem_step_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_wr && csr_paddr[2] == fee_pkg::REG_DELAY) begin
            rem_busy_ff  <= 1'b1;
            rem_step_ff  <= STEP_TOP;
            drain_rem_ff <= drain_index_ff;
         end else if (rem_busy_ff) begin
            if ({{DW{1'b0}}, drain_rem_ff} >= rem_trial) begin
               drain_rem_ff <= drain_rem_ff - rem_trial[DW-1:0];
            end
            if (rem_step_ff == '0) begin
               rem_busy_ff <= 1'b0;
            end
            rem_step_ff <= rem_step_ff - STEP_W'(1);
         end else if (accept) begin
            // While the tail runs, drain_index stays below D
            drain_rem_ff <= drain_index_in;
         end
         if (accept) begin
            wp_ff          <= wp_in;
            clip_count_ff  <= clip_count_in;
            drain_index_ff <= drain_index_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // History RAM: one registered read per transfer, one write per sample transfer
   // ---------------------------------------------------------------------
   fee_pkg::sample_type ring_mem [MAX_DELAY_DEPTH];

   always_ff @(posedge clock) begin
      if (accept && is_sample) begin
         ring_mem[wp_ff] <= req_chan.in_sample;
      end
      if (accept) begin
         ram_q_ff <= ring_mem[rd_addr];
      end
   end

   // Stage 1 payload: hold while the result register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_mode_ff <= MODE_ZERO;
         s1_done_ff <= 1'b0;
      end else if (accept) begin
         s1_mode_ff <= s1_mode_in;
         s1_done_ff <= s1_done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_x_ff <= req_chan.in_sample;
      end
   end

   // ---------------------------------------------------------------------
   // Mix: one 16x17 multiply, then truncating divide by a power of two
   // ---------------------------------------------------------------------
   fee_pkg::sample_type     xd_sel;
   logic signed [16:0]      gain_s;
   logic signed [32:0]      prod;
   logic signed [33:0]      mix_sum, mix_adj;
   logic signed [32:0]      tail_adj;

   assign xd_sel   = (s1_mode_ff == MODE_MIX_SELF) ? s1_x_ff : ram_q_ff;
   assign gain_s   = {1'b0, gain_ff};
   assign prod     = xd_sel * gain_s;
   assign mix_sum  = {{3{s1_x_ff[15]}}, s1_x_ff, 15'b0} + {prod[32], prod};
   assign mix_adj  = mix_sum + (mix_sum[33] ? 34'sd65535 : 34'sd0);
   assign tail_adj = prod + (prod[32] ? 33'sd32767 : 33'sd0);

   always_comb begin
      case (s1_mode_ff) inside
         MODE_PASS:                   out_sample_in = s1_x_ff;
         MODE_MIX_SELF, MODE_MIX_RAM: out_sample_in = mix_adj[31:16];
         MODE_TAIL:                   out_sample_in = tail_adj[30:15];
         default:                     out_sample_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_sample_ff <= out_sample_in;
         tail_done_ff  <= s1_done_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.out_sample = out_sample_ff;
   assign rsp_chan.tail_done  = tail_done_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rem_busy_ff |-> !accept)
      else $error("request transfer during remainder rebuild");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !out_free && !accept) |=>
         (s1_valid_ff && $stable(s1_x_ff) && $stable(s1_mode_ff)))
      else $error("RAM stage lost data under stall");

   a_tail_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_done_in) |=> (clip_count_ff == '0 && drain_index_ff == '0))
      else $error("clip state not cleared after final tail");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_chan.valid)
      else $error("result register missed a transfer");

endmodule
